// ===== design/plr_pkg.sv =====
`default_nettype none

package plr_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int PHASE_W         = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int OUTPUT_RATE_DEF = 48000;
    localparam int RATE_LOW        = 8000;
    localparam int RATE_HIGH       = 48000;
    localparam int MAX_RESULTS     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RATE_RESET   = 16'd11025;
    localparam logic [CFG_DATA_W-1:0] LENGTH_RESET = 16'd1;

    localparam logic FMT_U8  = 1'b0;
    localparam logic FMT_S16 = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TOTAL,
        ST_CHECK,
        ST_PUSH
    } plr_state_t;

    typedef struct packed {
        logic load;
        logic div_total;
        logic store_step;
        logic store_total;
        logic mul;
        logic push;
        logic finish;
    } plr_cmd_t;

    typedef struct packed {
        logic sound_start;
        logic div_done;
        logic more;
        logic out_free;
    } plr_stat_t;

endpackage

`default_nettype wire

// ===== design/plr_div.sv =====
`default_nettype none

module plr_div #(
    parameter int DVD_W = 32,
    parameter int DSR_W = 17
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire  [DVD_W-1:0] dividend,
    input  wire  [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DSR_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DSR_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[DSR_W-1:0];
            end
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/plr_ctrl.sv =====
`default_nettype none

module plr_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire plr_pkg::plr_stat_t  stat,
    output plr_pkg::plr_cmd_t        cmd
);
    import plr_pkg::*;

    plr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (stat.sound_start) begin
                        cmd.store_step = 1'b1;
                        cmd.div_total  = 1'b1;
                        state_next     = ST_DIV_TOTAL;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DIV_TOTAL: begin
                if (stat.div_done) begin
                    cmd.store_total = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.more) begin
                    cmd.mul    = 1'b1;
                    state_next = ST_PUSH;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/plr_dp.sv =====
`default_nettype none

module plr_dp #(
    parameter int OUTPUT_RATE = plr_pkg::OUTPUT_RATE_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire  [plr_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire  [plr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  wire  [plr_pkg::SAMPLE_W-1:0]        s_raw_sample,
    input  wire  plr_pkg::plr_cmd_t             cmd,
    output plr_pkg::plr_stat_t                  stat,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [plr_pkg::SAMPLE_W-1:0] m_out_sample,
    output logic                                m_final_res
);
    import plr_pkg::*;

    localparam int DSR_W  = ($clog2(OUTPUT_RATE + 1) > 16) ? $clog2(OUTPUT_RATE + 1) : 16;
    localparam int PRD_W  = $clog2(64'd65535 * OUTPUT_RATE + 1);
    localparam int DVD_W  = (PRD_W > PHASE_W) ? PRD_W : PHASE_W;
    localparam int STEP_W = $clog2((64'd65536 * RATE_HIGH) / OUTPUT_RATE + 1);
    localparam int TOT_W  = $clog2((64'd65535 * OUTPUT_RATE) / RATE_LOW + 1);
    localparam int N_W    = $clog2(MAX_RESULTS + 1);
    localparam logic [DSR_W-1:0] ORATE_C = DSR_W'(OUTPUT_RATE);
    // reciprocal of the output rate, exact for every clamped rate
    localparam int RCP_SH = $clog2(RATE_HIGH + 1) + $clog2(OUTPUT_RATE + 1);
    localparam longint unsigned RCP_C =
        ((64'd1 << (16 + RCP_SH)) + 64'(OUTPUT_RATE) - 64'd1) / 64'(OUTPUT_RATE);
    localparam int RCP_W  = $clog2(RCP_C + 1);
    localparam int STPP_W = (16 + RCP_W > RCP_SH + STEP_W) ? 16 + RCP_W : RCP_SH + STEP_W;

    logic [CFG_DATA_W-1:0] rate_reg, len_reg;
    logic                  fmt_reg;

    logic [15:0]                rate_clamp, len_eff;
    logic [DVD_W-1:0]           div_dividend, div_quotient, len_wide, orate_wide;
    logic [DSR_W-1:0]           div_divisor;
    logic                       div_start, div_done;
    logic [STPP_W-1:0]          step_prod;

    logic signed [SAMPLE_W-1:0] cur_reg, prev_reg, decoded;
    logic [15:0]                src_idx_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [TOT_W-1:0]           idx_reg, total_reg;
    logic [N_W-1:0]             n_reg;
    logic signed [33:0]         prod_reg, prod_next;
    logic                       copy_reg, fin_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_final_reg;

    logic                       last, interp, more, is_end, fin;
    logic signed [16:0]         diff, frac_s;
    logic [TOT_W:0]             idx_inc;
    logic [17:0]                interp_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
            len_reg  <= LENGTH_RESET;
            fmt_reg  <= FMT_U8;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SOURCE_RATE:   rate_reg <= cfg_wr_data;
                CFG_SOURCE_LENGTH: len_reg  <= cfg_wr_data;
                CFG_SAMPLE_FORMAT: fmt_reg  <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (rate_reg < 16'(RATE_LOW)) begin
            rate_clamp = 16'(RATE_LOW);
        end else if (rate_reg > 16'(RATE_HIGH)) begin
            rate_clamp = 16'(RATE_HIGH);
        end else begin
            rate_clamp = rate_reg;
        end
    end

    assign len_eff    = (len_reg == 16'd0) ? 16'd1 : len_reg;
    assign len_wide   = DVD_W'(len_eff);
    assign orate_wide = DVD_W'(ORATE_C);

    // step: (rate << 16) / output rate by reciprocal multiply
    assign step_prod = STPP_W'(rate_clamp) * STPP_W'(RCP_C);

    // total: length * output rate / rate on the serial divider
    assign div_start    = cmd.div_total;
    assign div_dividend = len_wide * orate_wide;
    assign div_divisor  = DSR_W'(rate_clamp);

    plr_div #(
        .DVD_W (DVD_W),
        .DSR_W (DSR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign decoded = (fmt_reg == FMT_S16) ? s_raw_sample
                                          : {s_raw_sample[7:0] ^ 8'h80, 8'h00};

    assign last    = src_idx_reg >= (len_eff - 16'd1);
    assign interp  = (src_idx_reg != 16'd0) && (phase_reg[PHASE_W-1:16] < src_idx_reg);
    assign more    = (n_reg < N_W'(MAX_RESULTS)) && (idx_reg < total_reg) && (interp || last);
    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign is_end  = idx_inc == {1'b0, total_reg};
    assign fin     = is_end || (last && n_reg == N_W'(MAX_RESULTS - 1));

    assign diff      = {cur_reg[15], cur_reg} - {prev_reg[15], prev_reg};
    assign frac_s    = {1'b0, phase_reg[15:0]};
    assign prod_next = diff * frac_s;
    // floor of the product over 65536 is its upper bits
    assign interp_sum = {{2{prev_reg[15]}}, prev_reg} + prod_reg[33:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_idx_reg <= '0;
            prev_reg    <= '0;
            phase_reg   <= '0;
            step_reg    <= '0;
            idx_reg     <= '0;
            total_reg   <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                n_reg <= '0;
            end
            if (cmd.store_step) begin
                step_reg <= step_prod[RCP_SH +: STEP_W];
            end
            if (cmd.store_total) begin
                total_reg <= div_quotient[TOT_W-1:0];
                phase_reg <= '0;
                idx_reg   <= '0;
            end
            if (cmd.push) begin
                idx_reg   <= idx_inc[TOT_W-1:0];
                phase_reg <= phase_reg + PHASE_W'(step_reg);
                n_reg     <= n_reg + 1'b1;
            end
            if (cmd.finish) begin
                prev_reg    <= cur_reg;
                src_idx_reg <= last ? 16'd0 : src_idx_reg + 16'd1;
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg <= decoded;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
            copy_reg <= !interp;
            fin_reg  <= fin;
        end
        if (cmd.push) begin
            m_sample_reg <= copy_reg ? cur_reg : interp_sum[15:0];
            m_final_reg  <= fin_reg;
        end
    end

    assign stat.sound_start = src_idx_reg == 16'd0;
    assign stat.div_done    = div_done;
    assign stat.more        = more;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;
    assign m_final_res  = m_final_reg;

endmodule

`default_nettype wire

// ===== design/pcm_linear_resampler.sv =====
// pcm_linear_resampler: mono pcm sample-rate converter by linear interpolation
// source samples enter on s_valid/s_ready (s_raw_sample), results leave on
// m_valid/m_ready as m_out_sample with m_final_res on the last one of a sound
// source_rate, source_length and sample_format are set through cfg_wr_* while idle
// the first item of a sound takes the phase step from a reciprocal multiply and
// runs a one-bit-per-cycle divider for the output count
// an item is worked in steps: accept it, then for each result a multiply and a
// load of the output register, and last a close of the item; one item is in
// work at a time
// at most 64 results per item; the last item of a sound emits the remaining
// results as copies of itself
// a single output register holds each result; when the receiver stalls the
// controller waits in front of it, and a new item is taken as soon as the
// previous one has handed over its last result
// reset (aresetn low, synchronous) restores the register defaults, drops any
// pending result and returns to the start of a sound
`default_nettype none

module pcm_linear_resampler #(
    parameter int OUTPUT_RATE = plr_pkg::OUTPUT_RATE_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire  [plr_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire  [plr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [plr_pkg::SAMPLE_W-1:0]        s_raw_sample,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [plr_pkg::SAMPLE_W-1:0] m_out_sample,
    output logic                                m_final_res
);
    import plr_pkg::*;

    plr_cmd_t  cmd;
    plr_stat_t stat;

    plr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    plr_dp #(
        .OUTPUT_RATE (OUTPUT_RATE)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_raw_sample (s_raw_sample),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_final_res  (m_final_res)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> stat.out_free)
        else $error("result overwrites one not yet taken");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> !s_ready && !cmd.push)
        else $error("divider finished outside sound start");

    a_result_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> m_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== sim/tb_pcm_linear_resampler.sv =====
`default_nettype none

module tb_pcm_linear_resampler;

    import plr_pkg::*;

    localparam int OUT_RATE      = OUTPUT_RATE_DEF;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pcm;
        logic                       fin;
    } pcm_out_t;

    typedef struct packed {
        logic                wr;
        logic [15:0]         rate;
        logic [15:0]         len;
        logic                fmt;
        logic [SAMPLE_W-1:0] raw;
        logic                typed;
        logic [SAMPLE_W-1:0] want;
        logic [7:0]          cnt;
    } step_row_t;

    logic                       aclk;
    logic                       aresetn      = 1'b0;
    logic                       cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wr_data  = '0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [SAMPLE_W-1:0]        s_raw_sample = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_sample;
    logic                       m_final_res;

    // resampler state as seen from outside
    int unsigned     cfg_rate = RATE_RESET;
    int unsigned     cfg_len  = LENGTH_RESET;
    logic            cfg_fmt  = FMT_U8;
    int              prev_pcm = 0;
    longint unsigned acc_phase = 0;
    int unsigned     acc_step  = 0;
    int unsigned     src_pos   = 0;
    int unsigned     out_pos   = 0;
    int unsigned     out_total = 0;

    pcm_out_t pcm_fresh[$];
    pcm_out_t pcm_due[$];

    int mismatch_count = 0;
    int src_idle       = 0;
    int snk_stall      = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    step_row_t plan [22] = '{
        '{0, 0,     0,     FMT_U8,  16'h00FF, 1, 16'h7F00, 4},
        '{1, 8000,  1,     FMT_U8,  16'hFF00, 1, 16'h8000, 6},
        '{1, 48000, 0,     FMT_S16, 16'h7FFF, 1, 16'h7FFF, 1},
        '{1, 0,     1,     FMT_S16, 16'h8000, 1, 16'h8000, 6},
        '{1, 65535, 1,     FMT_S16, 16'h0001, 1, 16'h0001, 1},
        '{1, 7999,  1,     FMT_U8,  16'h5A80, 1, 16'h0000, 6},
        '{1, 48001, 1,     FMT_U8,  16'hFF7F, 1, 16'hFF00, 1},
        '{1, 22050, 4,     FMT_S16, 16'h8000, 1, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'h7FFF, 0, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'h8000, 0, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'h1234, 0, 16'h0000, 0},
        '{1, 8000,  65535, FMT_U8,  16'h0000, 1, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'h00FF, 0, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'hFF00, 0, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'h1280, 0, 16'h0000, 0},
        // length cut below the position mid-sound, tail capped
        '{1, 8000,  3,     FMT_S16, 16'hC000, 0, 16'h0000, 0},
        '{1, 12345, 65535, FMT_S16, 16'h0100, 1, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'hFEFF, 0, 16'h0000, 0},
        // format and length change mid-sound
        '{1, 12345, 2,     FMT_U8,  16'h8080, 0, 16'h0000, 0},
        '{1, 44100, 65535, FMT_S16, 16'hFFFF, 1, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'h0000, 0, 16'h0000, 0},
        '{0, 0,     0,     FMT_U8,  16'h7FFF, 0, 16'h0000, 0}
    };

    pcm_linear_resampler #(
        .OUTPUT_RATE(OUT_RATE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_raw_sample(s_raw_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_sample(m_out_sample),
        .m_final_res(m_final_res)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int decode_pcm(logic [SAMPLE_W-1:0] raw);
        if (cfg_fmt == FMT_U8) begin
            return (int'(raw[7:0]) - 128) * 256;
        end
        return int'($signed(raw));
    endfunction

    function automatic int lerp_pcm(int s0, int s1, logic [15:0] frac);
        longint prod;
        prod = longint'(s1 - s0) * longint'(frac);
        return s0 + int'(prod >>> 16);
    endfunction

    task automatic push_fresh(int v);
        pcm_fresh.push_back('{pcm: 16'(v), fin: (out_pos + 1 == out_total)});
        out_pos++;
        acc_phase += acc_step;
    endtask

    // advance the resampler by one source item, results go to pcm_fresh
    task automatic resample_item(logic [SAMPLE_W-1:0] raw);
        int unsigned len;
        int unsigned k;
        int unsigned rate;
        int          cur;
        bit          last;
        len = (cfg_len == 0) ? 1 : cfg_len;
        k   = src_pos;
        cur = decode_pcm(raw);
        pcm_fresh.delete();
        if (k == 0) begin
            rate = cfg_rate;
            if (rate < RATE_LOW) rate = RATE_LOW;
            if (rate > RATE_HIGH) rate = RATE_HIGH;
            acc_step  = int'((longint'(rate) << 16) / OUT_RATE);
            out_total = int'((longint'(len) * OUT_RATE) / rate);
            acc_phase = 0;
            out_pos   = 0;
        end
        last = (k >= len - 1);
        if (k >= 1) begin
            while (pcm_fresh.size() < MAX_RESULTS && out_pos < out_total &&
                   (acc_phase >> 16) <= longint'(k - 1)) begin
                push_fresh(lerp_pcm(prev_pcm, cur, acc_phase[15:0]));
            end
        end
        if (last) begin
            while (pcm_fresh.size() < MAX_RESULTS && out_pos < out_total) begin
                push_fresh(cur);
            end
            if (out_pos < out_total && pcm_fresh.size() > 0) begin
                pcm_fresh[$].fin = 1'b1;
            end
            src_pos = 0;
        end else begin
            src_pos = (k + 1) & 16'hFFFF;
        end
        prev_pcm = cur;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        case (idx)
            CFG_SOURCE_RATE:   cfg_rate = data;
            CFG_SOURCE_LENGTH: cfg_len  = data;
            CFG_SAMPLE_FORMAT: cfg_fmt  = data[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(int unsigned rate, int unsigned len, logic fmt);
        write_reg(CFG_SOURCE_RATE, 16'(rate));
        write_reg(CFG_SOURCE_LENGTH, 16'(len));
        write_reg(CFG_SAMPLE_FORMAT, {15'($urandom), fmt});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pcm_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] raw, logic typed,
                               logic [SAMPLE_W-1:0] want, int cnt);
        int i;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_raw_sample <= raw;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        resample_item(raw);
        if (typed) begin
            pcm_fresh.delete();
            for (i = 0; i < cnt; i++) begin
                pcm_fresh.push_back('{pcm: want, fin: (i == cnt - 1)});
            end
        end
        foreach (pcm_fresh[i]) pcm_due.push_back(pcm_fresh[i]);
    endtask

    // receiver
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall);
            end
        end
    end

    always @(posedge aclk) begin : check_out
        pcm_out_t want_out;
        if (aresetn && m_valid && m_ready) begin
            if (pcm_due.size() == 0) begin
                $error("unexpected item: out_sample %0d final_res %0b",
                       m_out_sample, m_final_res);
                mismatch_count++;
            end else begin
                want_out = pcm_due.pop_front();
                if (m_out_sample !== want_out.pcm) begin
                    $error("out_sample: expected %0d, got %0d", want_out.pcm, m_out_sample);
                    mismatch_count++;
                end
                if (m_final_res !== want_out.fin) begin
                    $error("final_res: expected %0b, got %0b", want_out.fin, m_final_res);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int          idle_plan [4];
        int          stall_plan [4];
        int          lvl;
        int          fed;
        int          n;
        int unsigned rate_pick;
        int unsigned len_pick;
        int unsigned burst;
        logic        fmt_pick;
        idle_plan  = '{0, 68, 0, 6};
        stall_plan = '{0, 0, 68, 6};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_wr_en <= 1'b0;

        foreach (plan[r]) begin
            if (plan[r].wr) begin
                wait_idle();
                configure(plan[r].rate, plan[r].len, plan[r].fmt);
            end
            send_sample(plan[r].raw, plan[r].typed, plan[r].want, plan[r].cnt);
        end

        // long receiver hold while items keep coming
        wait_idle();
        configure(RATE_LOW, 4, FMT_S16);
        hold_req = 300;
        repeat (8) send_sample(16'($urandom), 1'b0, '0, 0);

        for (lvl = 0; lvl < 4; lvl++) begin
            wait_idle();
            src_idle  = idle_plan[lvl];
            snk_stall = stall_plan[lvl];
            fed = 0;
            while (fed < 48) begin
                wait_idle();
                case ($urandom_range(9))
                    0: rate_pick = $urandom_range(RATE_LOW - 1);
                    1: rate_pick = $urandom_range(65535, RATE_HIGH + 1);
                    2: rate_pick = RATE_LOW;
                    3: rate_pick = RATE_HIGH;
                    default: rate_pick = $urandom_range(RATE_HIGH, RATE_LOW);
                endcase
                case ($urandom_range(19))
                    0: len_pick = 0;
                    1: len_pick = 65535;
                    2, 3: len_pick = $urandom_range(20, 9);
                    default: len_pick = $urandom_range(8, 1);
                endcase
                fmt_pick = $urandom_range(1) ? FMT_S16 : FMT_U8;
                if (len_pick > 20) begin
                    burst = $urandom_range(12, 1);
                end else if ($urandom_range(4) == 0) begin
                    burst = $urandom_range(len_pick + 2, 1);
                end else begin
                    burst = $urandom_range(3, 1) * ((len_pick == 0) ? 1 : len_pick);
                end
                configure(rate_pick, len_pick, fmt_pick);
                for (n = 0; n < burst; n++) begin
                    send_sample(16'($urandom), 1'b0, '0, 0);
                    fed++;
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
